// ===== rtl/lsa_pkg.sv =====
// lsa_pkg: shared types and codes for the LRU slot allocator.
// Used by lsa_cell and lru_slot_allocator; depends on nothing.
`default_nettype none

package lsa_pkg;

    // Field widths fixed by the external interface
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned TOTAL_W  = 3;

    // Request codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_LOOKUP  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Per-cell operation for one transaction
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_BOTH,
        CELL_SHIFT_REC,
        CELL_RELEASE,
        CELL_CLEAR
    } t_cell_op;

    // Control handed from the top level to each cell
    typedef struct packed {
        t_cell_op op;
        logic     rec_clr;    // this cell holds the oldest used slot
        logic     free_load;  // this cell is the free-list tail position
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/lsa_cell.sv =====
// lsa_cell: one position of the recency list and of the free list.
// Depends on lsa_pkg; instantiated in a row by lru_slot_allocator.
`default_nettype none

module lsa_cell #(
    parameter int unsigned SLOT_BITS = 3,
    parameter int unsigned FREE_INIT = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lsa_pkg::t_cell_ctl    i_ctl,
    input  wire logic [SLOT_BITS-1:0]  i_rec_left,   // recency entry of the newer neighbor
    input  wire logic [SLOT_BITS-1:0]  i_free_right, // free entry of the next neighbor
    input  wire logic [SLOT_BITS-1:0]  i_rel_slot,   // slot returned to the free list
    output logic      [SLOT_BITS-1:0]  o_rec,
    output logic      [SLOT_BITS-1:0]  o_free
);
    import lsa_pkg::*;

    logic [SLOT_BITS-1:0] r_rec;
    logic [SLOT_BITS-1:0] r_free;

    // Entry update: shift with neighbors, point release, or restore
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec  <= '0;
            r_free <= SLOT_BITS'(FREE_INIT);
        end else begin
            unique case (i_ctl.op)
                CELL_HOLD: begin
                end
                CELL_SHIFT_BOTH: begin
                    r_rec  <= i_rec_left;
                    r_free <= i_free_right;
                end
                CELL_SHIFT_REC: begin
                    r_rec <= i_rec_left;
                end
                CELL_RELEASE: begin
                    if (i_ctl.rec_clr) begin
                        r_rec <= '0;
                    end
                    if (i_ctl.free_load) begin
                        r_free <= i_rel_slot;
                    end
                end
                CELL_CLEAR: begin
                    r_rec  <= '0;
                    r_free <= SLOT_BITS'(FREE_INIT);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rec  = r_rec;
    assign o_free = r_free;

endmodule

`default_nettype wire

// ===== rtl/lru_slot_allocator.sv =====
// lru_slot_allocator: top level, a row of lsa_cell entries plus result register.
// Depends on lsa_pkg and lsa_cell.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  request | i_in_valid o_in_ready i_action            | in
//          | i_recency_index                           |
//  result  | o_out_valid i_out_ready o_status o_slot   | out
//          | o_used_total o_is_full o_is_empty         |
//
// Within a transaction all cells shift or update together at the edge where
// it is accepted, and its result is registered at the same edge.
// A new request is taken every cycle while the result register is empty or
// being drained; a stalled result blocks new requests until it is drained.
// Synchronous reset puts the lists in their initial order.
`default_nettype none

module lru_slot_allocator #(
    parameter int unsigned SLOTS = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [lsa_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [lsa_pkg::INDEX_W-1:0]   i_recency_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_status,
    output logic      [lsa_pkg::SLOT_W-1:0]    o_slot,
    output logic      [lsa_pkg::TOTAL_W-1:0]   o_used_total,
    output logic                               o_is_full,
    output logic                               o_is_empty
);
    import lsa_pkg::*;

    localparam int unsigned SW = $clog2(SLOTS + 1);        // slot number and count
    localparam int unsigned PW = $clog2(SLOTS);            // list position
    localparam int unsigned XW = (SW > INDEX_W) ? SW : INDEX_W;

    logic [SW-1:0] w_rec  [SLOTS];
    logic [SW-1:0] w_free [SLOTS];
    logic [SW-1:0] w_rec_left   [SLOTS];
    logic [SW-1:0] w_free_right [SLOTS];
    t_cell_ctl     w_ctl  [SLOTS];

    logic [SW-1:0] r_count;
    logic [SW-1:0] n_count;

    logic          r_out_valid;
    logic          r_status;
    logic [SLOT_W-1:0]  r_slot;
    logic [TOTAL_W-1:0] r_used;
    logic          r_full;
    logic          r_empty;

    logic          w_accept;
    t_action       w_act;
    logic          w_full;
    logic          w_empty;
    logic [SW-1:0] w_ins_slot;
    logic [XW-1:0] w_idx;
    logic          w_idx_ok;
    logic [XW-1:0] w_rd_pos;
    logic [SW-1:0] w_rd_slot;
    logic [SW-1:0] w_last;
    logic [SW-1:0] w_free_pos;
    t_cell_op      w_op;
    logic          n_status;
    logic [SW-1:0] n_slot;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_act    = t_action'(i_action);
    assign w_full   = (r_count == SW'(SLOTS));
    assign w_empty  = (r_count == '0);

    // Slot pushed to the front: free head, or the oldest slot when full
    assign w_ins_slot = w_full ? w_rec[SLOTS-1] : w_free[0];

    // Lookup index check
    assign w_idx    = XW'(i_recency_index);
    assign w_idx_ok = (w_idx != '0) && (w_idx <= XW'(r_count));

    // One shared read port: lookup position or oldest used position
    assign w_rd_pos  = (w_act == ACT_LOOKUP) ? (w_idx - XW'(1)) : (XW'(r_count) - XW'(1));
    assign w_rd_slot = (w_rd_pos < XW'(SLOTS)) ? w_rec[w_rd_pos[PW-1:0]] : '0;

    assign w_last     = r_count - SW'(1);
    assign w_free_pos = SW'(SLOTS) - r_count;

    // Operation broadcast to the row, result and next count
    always_comb begin
        w_op     = CELL_HOLD;
        n_status = STATUS_OK;
        n_slot   = '0;
        n_count  = r_count;
        unique case (w_act)
            ACT_ALLOC: begin
                n_slot = w_ins_slot;
                if (w_full) begin
                    w_op = CELL_SHIFT_REC;
                end else begin
                    w_op    = CELL_SHIFT_BOTH;
                    n_count = r_count + SW'(1);
                end
            end
            ACT_LOOKUP: begin
                if (w_idx_ok) begin
                    n_slot = w_rd_slot;
                end else begin
                    n_status = STATUS_BAD;
                end
            end
            ACT_RELEASE: begin
                if (w_empty) begin
                    n_status = STATUS_BAD;
                end else begin
                    w_op    = CELL_RELEASE;
                    n_slot  = w_rd_slot;
                    n_count = r_count - SW'(1);
                end
            end
            ACT_CLEAR: begin
                w_op    = CELL_CLEAR;
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!w_accept) begin
            w_op = CELL_HOLD;
        end
    end

    // Row of cells, each linked to its neighbors
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_rec_left[g] = w_ins_slot;
        end else begin : g_body
            assign w_rec_left[g] = w_rec[g-1];
        end
        if (g == SLOTS - 1) begin : g_tail
            assign w_free_right[g] = '0;
        end else begin : g_inner
            assign w_free_right[g] = w_free[g+1];
        end

        assign w_ctl[g] = '{op:        w_op,
                            rec_clr:   (w_last == SW'(g)),
                            free_load: (w_free_pos == SW'(g))};

        lsa_cell #(
            .SLOT_BITS (SW),
            .FREE_INIT (g + 1)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_rec_left   (w_rec_left[g]),
            .i_free_right (w_free_right[g]),
            .i_rel_slot   (w_rd_slot),
            .o_rec        (w_rec[g]),
            .o_free       (w_free[g])
        );
    end

    // Used count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_slot   <= SLOT_W'(n_slot);
            r_used   <= TOTAL_W'(XW'(n_count));
            r_full   <= (n_count == SW'(SLOTS));
            r_empty  <= (n_count == '0);
        end
    end

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_used_total = r_used;
    assign o_is_full    = r_full;
    assign o_is_empty   = r_empty;

    // Count never exceeds the number of slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(SLOTS))
        else $error("used count out of range");

    // Clear-all leaves nothing used
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_act == ACT_CLEAR) |=> (r_count == '0) && r_empty)
        else $error("clear did not empty the allocator");

    // Allocate always succeeds with a real slot
    a_alloc_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_act == ACT_ALLOC) |-> (w_ins_slot != '0))
        else $error("allocate produced slot zero");

    // Full and empty flags never both set on a result
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_full && o_is_empty))
        else $error("full and empty both set");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for lru_slot_allocator (request -> one result).
// Depends on lsa_pkg and lru_slot_allocator; keeps its own model of both lists.
`timescale 1ns / 100ps

module testbench;
    import lsa_pkg::*;

    localparam int NSLOTS      = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 232;

    typedef struct packed {
        logic                status;
        logic [SLOT_W-1:0]   slot;
        logic [TOTAL_W-1:0]  total;
        logic                full;
        logic                empty;
    } t_result;

    typedef struct packed {
        t_action             act;
        logic [INDEX_W-1:0]  idx;
        logic                typed;
        t_result             want;
    } t_row;

    // DUT ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [ACTION_W-1:0] i_action = '0;
    logic [INDEX_W-1:0]  i_recency_index = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [TOTAL_W-1:0]  o_used_total;
    logic                o_is_full;
    logic                o_is_empty;

    // Bench state
    logic    row_typed = 1'b0;
    t_result row_result = '0;
    logic    rx_hold = 1'b0;
    int      tx_idle_pct = 0;
    int      rx_stall_pct = 0;
    int      cycles = 0;
    int      errors = 0;
    int      results_seen = 0;
    int      bad_seen = 0;
    int      full_seen = 0;
    int      act_seen [4] = '{0, 0, 0, 0};

    // Predictor state: used list (most recent first), free list, used count
    logic [SLOT_W-1:0] recent_q [NSLOTS];
    logic [SLOT_W-1:0] free_q [NSLOTS];
    int                used_n;
    t_result           pending_results [$];

    lru_slot_allocator #(.SLOTS(NSLOTS)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_recency_index (i_recency_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_used_total    (o_used_total),
        .o_is_full       (o_is_full),
        .o_is_empty      (o_is_empty)
    );

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void reset_lists();
        int k;
        for (k = 0; k < NSLOTS; k++) begin
            recent_q[k] = '0;
            free_q[k]   = SLOT_W'(k + 1);
        end
        used_n = 0;
    endfunction

    // One request against the model lists; returns the result it produces
    function automatic t_result allocator_step(t_action act, logic [INDEX_W-1:0] idx);
        t_result           r;
        logic [SLOT_W-1:0] s;
        int                k;
        r = '0;
        r.status = STATUS_OK;
        s = '0;
        case (act)
            ACT_ALLOC: begin
                if (used_n >= NSLOTS) begin
                    // full: oldest used slot is reused
                    s = recent_q[NSLOTS-1];
                end else begin
                    s = free_q[0];
                    for (k = 0; k < NSLOTS - 1; k++) free_q[k] = free_q[k+1];
                    free_q[NSLOTS-1] = '0;
                    used_n++;
                end
                for (k = NSLOTS - 1; k > 0; k--) recent_q[k] = recent_q[k-1];
                recent_q[0] = s;
            end
            ACT_LOOKUP: begin
                if (idx >= 1 && int'(idx) <= used_n) s = recent_q[idx-1];
                else r.status = STATUS_BAD;
            end
            ACT_RELEASE: begin
                if (used_n == 0) begin
                    r.status = STATUS_BAD;
                end else begin
                    s = recent_q[used_n-1];
                    recent_q[used_n-1] = '0;
                    free_q[NSLOTS-used_n] = s;
                    used_n--;
                end
            end
            default: reset_lists();
        endcase
        r.slot  = s;
        r.total = TOTAL_W'(used_n);
        r.full  = (used_n == NSLOTS);
        r.empty = (used_n == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        $display("%0t: result %0d %s mismatch: got %0d, want %0d",
                 $realtime, results_seen, field, got, want);
    endtask

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        i_out_ready <= !rx_hold &&
                       !(rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct);
    end

    // Result checking and request capture, both at the sampling edge
    always @(posedge i_clk) begin
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with no request outstanding", $realtime);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_slot !== want.slot)
                        report_mismatch("slot", o_slot, want.slot);
                    if (o_used_total !== want.total)
                        report_mismatch("used_total", o_used_total, want.total);
                    if (o_is_full !== want.full)
                        report_mismatch("is_full", o_is_full, want.full);
                    if (o_is_empty !== want.empty)
                        report_mismatch("is_empty", o_is_empty, want.empty);
                    if (want.status == STATUS_BAD) bad_seen++;
                    if (want.full) full_seen++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                pred = allocator_step(t_action'(i_action), i_recency_index);
                act_seen[i_action]++;
                // hand-written rows carry their own expectation
                pending_results.push_back(row_typed ? row_result : pred);
            end
        end
    end

    // Offer one request; returns at the edge where it is accepted
    task automatic offer_request(input t_action act, input logic [INDEX_W-1:0] idx,
                                 input logic typed, input t_result want);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_recency_index <= idx;
        row_typed       <= typed;
        row_result      <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic random_request();
        t_action            act;
        logic [INDEX_W-1:0] idx;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      act = ACT_ALLOC;
        else if (pick < 70) act = ACT_LOOKUP;
        else if (pick < 94) act = ACT_RELEASE;
        else                act = ACT_CLEAR;
        // mostly valid recency positions, some of the whole index range
        if ($urandom_range(0, 3) != 0) idx = INDEX_W'($urandom_range(1, NSLOTS));
        else                           idx = INDEX_W'($urandom_range(0, 7));
        offer_request(act, idx, 1'b0, '0);
    endtask

    // Stop sending; the last accepted request is queued by the next edge
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Directed rows: empty-list errors, fill to full, reuse, out-of-range, clear
    t_row stim_rows [23] = '{
        '{ACT_LOOKUP,  3'd1, 1'b1, '{STATUS_BAD, 3'd0, 3'd0, 1'b0, 1'b1}},
        '{ACT_RELEASE, 3'd0, 1'b1, '{STATUS_BAD, 3'd0, 3'd0, 1'b0, 1'b1}},
        '{ACT_LOOKUP,  3'd0, 1'b1, '{STATUS_BAD, 3'd0, 3'd0, 1'b0, 1'b1}},
        '{ACT_ALLOC,   3'd0, 1'b1, '{STATUS_OK,  3'd1, 3'd1, 1'b0, 1'b0}},
        '{ACT_ALLOC,   3'd7, 1'b0, '0},
        '{ACT_ALLOC,   3'd0, 1'b0, '0},
        '{ACT_ALLOC,   3'd0, 1'b0, '0},
        '{ACT_ALLOC,   3'd0, 1'b0, '0},
        '{ACT_ALLOC,   3'd0, 1'b0, '0},
        '{ACT_LOOKUP,  3'd5, 1'b0, '0},
        '{ACT_LOOKUP,  3'd1, 1'b0, '0},
        '{ACT_LOOKUP,  3'd6, 1'b1, '{STATUS_BAD, 3'd0, 3'd5, 1'b1, 1'b0}},
        '{ACT_LOOKUP,  3'd7, 1'b1, '{STATUS_BAD, 3'd0, 3'd5, 1'b1, 1'b0}},
        '{ACT_RELEASE, 3'd0, 1'b0, '0},
        '{ACT_RELEASE, 3'd3, 1'b0, '0},
        '{ACT_ALLOC,   3'd0, 1'b0, '0},
        '{ACT_LOOKUP,  3'd4, 1'b0, '0},
        '{ACT_CLEAR,   3'd0, 1'b1, '{STATUS_OK,  3'd0, 3'd0, 1'b0, 1'b1}},
        '{ACT_ALLOC,   3'd7, 1'b1, '{STATUS_OK,  3'd1, 3'd1, 1'b0, 1'b0}},
        '{ACT_RELEASE, 3'd0, 1'b1, '{STATUS_OK,  3'd1, 3'd0, 1'b0, 1'b1}},
        '{ACT_RELEASE, 3'd0, 1'b1, '{STATUS_BAD, 3'd0, 3'd0, 1'b0, 1'b1}},
        '{ACT_CLEAR,   3'd5, 1'b1, '{STATUS_OK,  3'd0, 3'd0, 1'b0, 1'b1}},
        '{ACT_LOOKUP,  3'd2, 1'b1, '{STATUS_BAD, 3'd0, 3'd0, 1'b0, 1'b1}}
    };

    // Main sequence
    initial begin
        int ph;
        int n;
        reset_lists();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r])
            offer_request(stim_rows[r].act, stim_rows[r].idx,
                          stim_rows[r].typed, stim_rows[r].want);
        drain_results();

        // idle mixes: none, sender idle, receiver stall, both light
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 62; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 62; end
                default: begin tx_idle_pct = 6;  rx_stall_pct = 6;  end
            endcase
            if (ph == 0) begin
                // receiver holds off while requests keep coming: input must stall
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            for (n = 0; n < PHASE_ITEMS; n++) random_request();
            if (ph == 1) drain_results();
        end

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests: %0d allocate, %0d lookup, %0d release, %0d clear",
                 act_seen[0] + act_seen[1] + act_seen[2] + act_seen[3],
                 act_seen[0], act_seen[1], act_seen[2], act_seen[3]);
        $display("%0d results checked, %0d invalid, %0d with all slots used, %0d mismatches",
                 results_seen, bad_seen, full_seen, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== lru_slot_allocator.f =====
rtl/lsa_pkg.sv
rtl/lsa_cell.sv
rtl/lru_slot_allocator.sv
sim/testbench.sv
